FILE: design/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat peer table package
// Shared widths, codes and reset values of the peer table block.
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int DEFAULT_SLOTS = 16;
	localparam int RES_CAP       = 16;
	localparam int ADDR_W        = 5;

	typedef enum logic [1:0] {
		MODE_HEARTBEAT = 2'd0,
		MODE_MESSAGE   = 2'd1,
		MODE_AGE       = 2'd2,
		MODE_SEND      = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_ACK      = 3'd0,
		KIND_DETECTED = 3'd1,
		KIND_FORWARD  = 3'd2,
		KIND_LOST     = 3'd3,
		KIND_SEND_TO  = 3'd4,
		KIND_FULL     = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		REG_BASE_X    = 3'd0,
		REG_BASE_Y    = 3'd1,
		REG_BASE_Z    = 3'd2,
		REG_MIN_LEVEL = 3'd3,
		REG_EXPIRY    = 3'd4
	} reg_idx_t;

	localparam logic signed [17:0] MIN_LEVEL_RESET = -18'sd120;
	localparam logic [15:0]        EXPIRY_RESET    = 16'd2000;

endpackage

FILE: design/hpt_in_if.sv
// ----------------------------------------------------------------------------
// Peer table input channel
// Valid/ready channel that carries one input item.
// ----------------------------------------------------------------------------
interface hpt_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [63:0]        station_key;
	logic signed [15:0] peer_x;
	logic signed [15:0] peer_y;
	logic signed [15:0] peer_z;
	logic [31:0]        peer_ip;
	logic [15:0]        peer_port;
	logic [31:0]        now_ms;
	logic [15:0]        target_id;

	modport source (output valid, mode, station_key, peer_x, peer_y, peer_z, peer_ip,
		peer_port, now_ms, target_id, input ready);
	modport sink (input valid, mode, station_key, peer_x, peer_y, peer_z, peer_ip,
		peer_port, now_ms, target_id, output ready);
endinterface

FILE: design/hpt_out_if.sv
// ----------------------------------------------------------------------------
// Peer table result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface hpt_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [15:0]        peer_id;
	logic signed [17:0] level;
	logic [31:0]        dest_ip;
	logic [15:0]        dest_port;
	logic               last;

	modport source (output valid, kind, peer_id, level, dest_ip, dest_port, last,
		input ready);
	modport sink (input valid, kind, peer_id, level, dest_ip, dest_port, last,
		output ready);
endinterface

FILE: design/heartbeat_peer_table_with_aging_unit.sv
// A heartbeat runs the shared squarer, the bit-serial square root and a key search of one slot
// per cycle; a message or single send runs the key search only. An aging tick or broadcast
// makes one selection pass over the slot table per result, and a last pass that ends the item.
// One item is in work at a time; a result waits in the output register. Reset (arst_n low,
// asynchronous) clears all slot valid bits, the id counter, the state, the output valid flag and the configuration.
// ----------------------------------------------------------------------------
// Heartbeat peer table with aging
// Keeps a peer table keyed by station id, answers heartbeats, ages entries
// and resolves send requests, one sequenced step per cycle while no result waits for the output register.
// ----------------------------------------------------------------------------
module heartbeat_peer_table_with_aging_unit #(
	parameter int TABLE_SLOTS = hpt_pkg::DEFAULT_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hpt_in_if.sink                      req,
	hpt_out_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hpt_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SQ   = 9'b000000010,
		ST_ROOT = 9'b000000100,
		ST_LVL  = 9'b000001000,
		ST_SCAN = 9'b000010000,
		ST_RES  = 9'b000100000,
		ST_DET  = 9'b001000000,
		ST_PASS = 9'b010000000,
		ST_PEND = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration
	logic signed [15:0] base_x_q, base_y_q, base_z_q;
	logic signed [17:0] min_level_q;
	logic [15:0]        expiry_q;

	// Table
	logic        slot_valid_q [TABLE_SLOTS];
	logic [63:0] slot_key_q   [TABLE_SLOTS];
	logic [15:0] slot_id_q    [TABLE_SLOTS];
	logic [31:0] slot_ip_q    [TABLE_SLOTS];
	logic [15:0] slot_port_q  [TABLE_SLOTS];
	logic [31:0] slot_seen_q  [TABLE_SLOTS];
	logic [15:0] id_counter_q;

	// Item
	hpt_pkg::mode_t     mode_q;
	logic [63:0]        key_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic [31:0]        ip_q, now_q;
	logic [15:0]        port_q, target_q;

	// Distance and root
	logic [1:0]         step_q;
	logic [34:0]        acc_q, rt_n_q, rt_res_q;
	logic [4:0]         rt_k_q;
	logic signed [17:0] level_q;

	// Scan
	logic [IDX_W-1:0] scan_i_q, hit_idx_q, free_idx_q, best_idx_q, prev_idx_q;
	logic             hit_q, free_q, best_found_q, prev_valid_q, pend_q;
	logic [15:0]      hit_id_q, hit_port_q, best_id_q, best_port_q, prev_id_q;
	logic [31:0]      hit_ip_q, best_ip_q;
	logic [15:0]      pend_id_q, pend_port_q;
	logic [31:0]      pend_ip_q;
	logic [4:0]       cnt_q;

	// Output register
	logic               ov_q, olast_q;
	hpt_pkg::kind_t     okind_q;
	logic [15:0]        oid_q, oport_q;
	logic signed [17:0] olevel_q;
	logic [31:0]        oip_q;

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = ov_q;
	assign rsp.kind      = okind_q;
	assign rsp.peer_id   = oid_q;
	assign rsp.level     = olevel_q;
	assign rsp.dest_ip   = oip_q;
	assign rsp.dest_port = oport_q;
	assign rsp.last      = olast_q;
	assign pready        = 1'b1;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (hpt_pkg::reg_idx_t'(paddr[4:2]))
			hpt_pkg::REG_BASE_X:    prdata = 32'(unsigned'(base_x_q));
			hpt_pkg::REG_BASE_Y:    prdata = 32'(unsigned'(base_y_q));
			hpt_pkg::REG_BASE_Z:    prdata = 32'(unsigned'(base_z_q));
			hpt_pkg::REG_MIN_LEVEL: prdata = 32'(unsigned'(min_level_q));
			hpt_pkg::REG_EXPIRY:    prdata = 32'(expiry_q);
			default:                prdata = 32'd0;
		endcase
	end

	// Shared squarer: one axis difference per cycle.
	logic signed [15:0] sq_a, sq_b;
	logic signed [16:0] sq_d;
	logic signed [33:0] sq_p;
	always_comb begin
		unique case (step_q)
			2'd0:    begin sq_a = base_x_q; sq_b = px_q; end
			2'd1:    begin sq_a = base_y_q; sq_b = py_q; end
			default: begin sq_a = base_z_q; sq_b = pz_q; end
		endcase
		sq_d = {sq_a[15], sq_a} - {sq_b[15], sq_b};
		sq_p = sq_d * sq_d;
	end

	// One square root step: bit weight 4^k.
	logic [34:0] rt_bit, rt_try;
	assign rt_bit = 35'd1 << {rt_k_q, 1'b0};
	assign rt_try = rt_res_q + rt_bit;

	logic signed [17:0] lvl_c;
	assign lvl_c = (rt_res_q[16:0] == 17'd0) ? -18'sd1
		: $signed(18'(~{1'b0, rt_res_q[16:0]} + 18'd1));

	logic [15:0] new_id;
	assign new_id = (id_counter_q == 16'hFFFF) ? 16'd1 : id_counter_q + 16'd1;

	// Current slot under the scan cursor.
	logic        cur_valid, cur_expired, cur_after, cur_cand;
	logic [15:0] cur_id;
	always_comb begin
		cur_valid   = slot_valid_q[scan_i_q];
		cur_id      = slot_id_q[scan_i_q];
		cur_expired = (now_q - slot_seen_q[scan_i_q]) > {16'd0, expiry_q};
		cur_after   = !prev_valid_q || (cur_id > prev_id_q)
			|| (cur_id == prev_id_q && scan_i_q > prev_idx_q);
		cur_cand    = cur_valid && cur_after && (mode_q != hpt_pkg::MODE_AGE || cur_expired);
	end

	// Result push request.
	logic           can_push, push;
	hpt_pkg::kind_t p_kind;
	logic [15:0]    p_id, p_port;
	logic [17:0]    p_level;
	logic [31:0]    p_ip;
	logic           p_last, take;
	assign can_push = !ov_q || rsp.ready;
	assign take     = best_found_q && (cnt_q < 5'(hpt_pkg::RES_CAP));

	always_comb begin
		push    = 1'b0;
		p_kind  = hpt_pkg::KIND_ACK;
		p_id    = 16'd0;
		p_level = 18'd0;
		p_ip    = 32'd0;
		p_port  = 16'd0;
		p_last  = 1'b1;
		unique case (state_q)
			ST_RES: begin
				if (mode_q == hpt_pkg::MODE_HEARTBEAT) begin
					if (hit_q) begin
						push    = 1'b1;
						p_id    = hit_id_q;
						p_level = level_q;
						p_ip    = ip_q;
						p_port  = port_q;
					end else if (!free_q) begin
						push   = 1'b1;
						p_kind = hpt_pkg::KIND_FULL;
					end
				end else if (hit_q) begin
					push = 1'b1;
					if (mode_q == hpt_pkg::MODE_MESSAGE) begin
						p_kind = hpt_pkg::KIND_FORWARD;
						p_id   = hit_id_q;
					end else begin
						p_kind = hpt_pkg::KIND_SEND_TO;
						p_id   = target_q;
						p_ip   = hit_ip_q;
						p_port = hit_port_q;
					end
				end
			end
			ST_DET: begin
				push   = 1'b1;
				p_kind = hpt_pkg::KIND_DETECTED;
				p_id   = new_id;
				p_last = 1'b0;
			end
			ST_PEND: begin
				push   = pend_q;
				p_last = !take;
				p_id   = pend_id_q;
				if (mode_q == hpt_pkg::MODE_AGE) begin
					p_kind = hpt_pkg::KIND_LOST;
				end else begin
					p_kind = hpt_pkg::KIND_SEND_TO;
					p_ip   = pend_ip_q;
					p_port = pend_port_q;
				end
			end
			default: push = 1'b0;
		endcase
	end

	logic do_push;
	assign do_push = push && can_push;

	// Table storage, written by the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == ST_DET && can_push) begin
			slot_key_q[free_idx_q] <= key_q;
			slot_id_q[free_idx_q]  <= new_id;
		end
		if (state_q == ST_RES && mode_q == hpt_pkg::MODE_HEARTBEAT && hit_q && can_push) begin
			slot_ip_q[hit_idx_q]   <= ip_q;
			slot_port_q[hit_idx_q] <= port_q;
			slot_seen_q[hit_idx_q] <= now_q;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (do_push) begin
			okind_q  <= p_kind;
			oid_q    <= p_id;
			olevel_q <= $signed(p_level);
			oip_q    <= p_ip;
			oport_q  <= p_port;
			olast_q  <= p_last;
		end
	end

	// Item and working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q   <= hpt_pkg::mode_t'(req.mode);
				key_q    <= req.station_key;
				px_q     <= req.peer_x;
				py_q     <= req.peer_y;
				pz_q     <= req.peer_z;
				ip_q     <= req.peer_ip;
				port_q   <= req.peer_port;
				now_q    <= req.now_ms;
				target_q <= req.target_id;
				step_q   <= 2'd0;
				acc_q    <= 35'd0;
				scan_i_q <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
				best_found_q <= 1'b0;
				prev_valid_q <= 1'b0;
				pend_q   <= 1'b0;
				cnt_q    <= 5'd0;
			end
			ST_SQ: begin
				acc_q  <= acc_q + {1'b0, sq_p};
				step_q <= step_q + 2'd1;
				rt_n_q   <= acc_q + {1'b0, sq_p};
				rt_res_q <= 35'd0;
				rt_k_q   <= 5'd17;
			end
			ST_ROOT: begin
				if (rt_n_q >= rt_try) begin
					rt_n_q   <= rt_n_q - rt_try;
					rt_res_q <= (rt_res_q >> 1) + rt_bit;
				end else begin
					rt_res_q <= rt_res_q >> 1;
				end
				rt_k_q <= rt_k_q - 5'd1;
			end
			ST_LVL: begin
				level_q  <= lvl_c;
				scan_i_q <= '0;
			end
			ST_SCAN: begin
				if (cur_valid && !hit_q && (mode_q == hpt_pkg::MODE_SEND ?
						cur_id == target_q : slot_key_q[scan_i_q] == key_q)) begin
					hit_q      <= 1'b1;
					hit_idx_q  <= scan_i_q;
					hit_id_q   <= cur_id;
					hit_ip_q   <= slot_ip_q[scan_i_q];
					hit_port_q <= slot_port_q[scan_i_q];
				end
				if (!cur_valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= scan_i_q;
				end
				scan_i_q <= scan_i_q + IDX_W'(1);
			end
			ST_DET: begin
				if (can_push) begin
					hit_q     <= 1'b1;
					hit_idx_q <= free_idx_q;
					hit_id_q  <= new_id;
				end
			end
			ST_PASS: begin
				// Ascending scan, so a strict compare keeps the lowest slot on equal ids.
				if (cur_cand && (!best_found_q || cur_id < best_id_q)) begin
					best_found_q <= 1'b1;
					best_idx_q   <= scan_i_q;
					best_id_q    <= cur_id;
					best_ip_q    <= slot_ip_q[scan_i_q];
					best_port_q  <= slot_port_q[scan_i_q];
				end
				scan_i_q <= scan_i_q + IDX_W'(1);
			end
			ST_PEND: begin
				if (take && (!pend_q || can_push)) begin
					pend_q       <= 1'b1;
					pend_id_q    <= best_id_q;
					pend_ip_q    <= best_ip_q;
					pend_port_q  <= best_port_q;
					cnt_q        <= cnt_q + 5'd1;
					prev_valid_q <= 1'b1;
					prev_id_q    <= best_id_q;
					prev_idx_q   <= best_idx_q;
					best_found_q <= 1'b0;
					scan_i_q     <= '0;
				end
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ov_q         <= 1'b0;
			id_counter_q <= 16'd0;
			base_x_q     <= 16'sd0;
			base_y_q     <= 16'sd0;
			base_z_q     <= 16'sd0;
			min_level_q  <= hpt_pkg::MIN_LEVEL_RESET;
			expiry_q     <= hpt_pkg::EXPIRY_RESET;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr) begin
				unique case (hpt_pkg::reg_idx_t'(paddr[4:2]))
					hpt_pkg::REG_BASE_X:    base_x_q    <= $signed(pwdata[15:0]);
					hpt_pkg::REG_BASE_Y:    base_y_q    <= $signed(pwdata[15:0]);
					hpt_pkg::REG_BASE_Z:    base_z_q    <= $signed(pwdata[15:0]);
					hpt_pkg::REG_MIN_LEVEL: min_level_q <= $signed(pwdata[17:0]);
					hpt_pkg::REG_EXPIRY:    expiry_q    <= pwdata[15:0];
					default: ;
				endcase
			end

			if (do_push) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						priority if (req.mode == hpt_pkg::MODE_HEARTBEAT) begin
							state_q <= ST_SQ;
						end else if (req.mode == hpt_pkg::MODE_AGE ||
								(req.mode == hpt_pkg::MODE_SEND && req.target_id == 16'd0)) begin
							state_q <= ST_PASS;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SQ: begin
					if (step_q == 2'd2) state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (rt_k_q == 5'd0) state_q <= ST_LVL;
				end
				ST_LVL: begin
					state_q <= (lvl_c < min_level_q) ? ST_IDLE : ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_i_q == LAST_IDX) state_q <= ST_RES;
				end
				ST_RES: begin
					if (mode_q == hpt_pkg::MODE_HEARTBEAT && !hit_q && free_q) begin
						state_q <= ST_DET;
					end else if (!push || can_push) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DET: begin
					if (can_push) begin
						id_counter_q <= new_id;
						slot_valid_q[free_idx_q] <= 1'b1;
						state_q <= ST_RES;
					end
				end
				ST_PASS: begin
					if (scan_i_q == LAST_IDX) state_q <= ST_PEND;
				end
				ST_PEND: begin
					if (take) begin
						if (!pend_q || can_push) begin
							if (mode_q == hpt_pkg::MODE_AGE) begin
								slot_valid_q[best_idx_q] <= 1'b0;
							end
							state_q <= ST_PASS;
						end
					end else if (!pend_q || can_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
